>>> hw/rtl/transfer_function_lerp_lookup_macros.svh
// Assertion macros shared by the transfer function lookup RTL.
// Depends on nothing; files that assert include it by its bare name.
`ifndef TRANSFER_FUNCTION_LERP_LOOKUP_MACROS_SVH
`define TRANSFER_FUNCTION_LERP_LOOKUP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define TFL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define TFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TFL_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define TFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> hw/rtl/tflerp_pkg.sv
// Shared types and constants of the transfer function lookup.
// Depends on nothing; the front, back and top level import it.
package tflerp_pkg;

   // Depth of the queue between the front and the back part.
   localparam int QDEPTH = 4;
   localparam int QCW    = $clog2(QDEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RANGE_LOWER = 3'd0,
      CSR_RANGE_UPPER = 3'd1,
      CSR_INDEX_SCALE = 3'd2,
      CSR_ENTRY_COUNT = 3'd3
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [31:0] RANGE_LOWER_RESET = 32'h0000_0000;
   localparam logic [31:0] RANGE_UPPER_RESET = 32'h0001_0000;
   localparam logic [31:0] INDEX_SCALE_RESET = 32'h0000_0000;
   localparam logic [8:0]  ENTRY_COUNT_RESET = 9'd0;

   // 1.0 in the 16-bit fraction format, and half an output step for rounding.
   localparam logic [16:0] FRAC_ONE   = 17'h1_0000;
   localparam logic [32:0] ROUND_HALF = 33'h0_0000_8000;

   // One table entry; red sits in the low bits.
   typedef struct packed {
      logic [15:0] alpha;
      logic [15:0] blue;
      logic [15:0] green;
      logic [15:0] red;
   } color_type;

   typedef struct packed {
      logic signed [31:0] range_lower;
      logic signed [31:0] range_upper;
      logic [31:0]        index_scale;
      logic [8:0]         entry_count;
   } cfg_type;

   // Work handed from the front to the back part, apart from the table indexes.
   typedef struct packed {
      logic        is_write;
      logic        zero;
      logic [15:0] frac;
      logic [7:0]  slot;
      color_type   color;
   } task_type;

endpackage

>>> hw/rtl/tflerp_if.sv
// Channel interfaces of the transfer function lookup: request and response.
// Depends on nothing.
interface tflerp_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic signed [31:0] sample_value;
   logic               sample_is_nan;
   logic [7:0]         entry_index;
   logic [15:0]        entry_red;
   logic [15:0]        entry_green;
   logic [15:0]        entry_blue;
   logic [15:0]        entry_alpha;

   modport source (
      output valid, req_type, sample_value, sample_is_nan, entry_index,
             entry_red, entry_green, entry_blue, entry_alpha,
      input  ready
   );
   modport sink (
      input  valid, req_type, sample_value, sample_is_nan, entry_index,
             entry_red, entry_green, entry_blue, entry_alpha,
      output ready
   );
endinterface

interface tflerp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_red;
   logic [15:0] out_green;
   logic [15:0] out_blue;
   logic [15:0] out_alpha;

   modport source (
      output valid, out_red, out_green, out_blue, out_alpha,
      input  ready
   );
   modport sink (
      input  valid, out_red, out_green, out_blue, out_alpha,
      output ready
   );
endinterface

>>> hw/rtl/tflerp_fifo.sv
// Small register queue between the front and the back part.
// Depends on the assertion macro header.
`include "transfer_function_lerp_lookup_macros.svh"
module tflerp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       not_empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data  = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

   `TFL_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "queue count beyond depth")
   `TFL_ASSERT_IMP(a_no_overflow, clock, reset, push, count_ff != CW'(DEPTH), "push into full queue")
   `TFL_ASSERT_NEXT(a_push_lands, clock, reset, push && !pop, count_ff != '0, "pushed beat lost")
endmodule

>>> hw/rtl/tflerp_front.sv
// Front part: accepts request beats, classifies samples and forms the table position.
// Depends on tflerp_pkg and the request interface.
module tflerp_front #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   tflerp_req_if.sink                             req_ch,
   input  tflerp_pkg::cfg_type                    cfg,
   input  logic [tflerp_pkg::QCW-1:0]             queue_count,
   output logic                                   push,
   output tflerp_pkg::task_type                   push_task,
   output logic [$clog2(MAX_ENTRIES)-1:0]         push_idx,
   output logic [$clog2(MAX_ENTRIES)-1:0]         push_nxt
);
   import tflerp_pkg::*;

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [1:0] {
      SEL_FIRST  = 2'd0,
      SEL_LAST   = 2'd1,
      SEL_INTERP = 2'd2
   } sel_type;

   // Stage A: classified request.
   logic            a_v_ff, a_v_in;
   logic            a_write_ff, a_write_in;
   logic            a_zero_ff, a_zero_in;
   sel_type         a_sel_ff, a_sel_in;
   logic [31:0]     a_diff_ff, a_diff_in;
   logic [IW-1:0]   a_last_ff, a_last_in;
   logic [7:0]      a_slot_ff;
   color_type       a_color_ff;

   // Stage B: position product.
   logic            b_v_ff;
   logic            b_write_ff;
   logic            b_zero_ff;
   sel_type         b_sel_ff;
   logic [63:0]     b_pos_ff, b_pos_in;
   logic [IW-1:0]   b_last_ff;
   logic [7:0]      b_slot_ff;
   color_type       b_color_ff;

   logic [CW-1:0]   count_eff;
   logic [31:0]     sample_diff;
   logic [QCW:0]    in_flight;
   logic [IW-1:0]   idx, nxt;
   logic [15:0]     frac;

   // Items in flight anywhere ahead of the back part must all fit in the queue.
   assign in_flight = (QCW+1)'(queue_count) + (QCW+1)'(a_v_ff) + (QCW+1)'(b_v_ff);
   assign req_ch.ready = (in_flight < (QCW+1)'(QDEPTH));

   always_comb begin
      if (32'(cfg.entry_count) > 32'(MAX_ENTRIES)) begin
         count_eff = CW'(MAX_ENTRIES);
      end else begin
         count_eff = CW'(cfg.entry_count);
      end
      // Only used inside the range, where the difference is positive and
      // below 2^32, so the low 32 bits hold it exactly.
      sample_diff = req_ch.sample_value - cfg.range_lower;
      a_v_in     = req_ch.valid && req_ch.ready;
      a_write_in = req_ch.req_type;
      a_zero_in  = req_ch.sample_is_nan || (count_eff == '0);
      a_diff_in  = sample_diff;
      a_last_in  = IW'(count_eff - CW'(1));
      // The lower bound wins when the range is inverted.
      if (req_ch.sample_value <= cfg.range_lower) begin
         a_sel_in = SEL_FIRST;
      end else if (req_ch.sample_value >= cfg.range_upper) begin
         a_sel_in = SEL_LAST;
      end else begin
         a_sel_in = SEL_INTERP;
      end
   end

   assign b_pos_in = 64'(a_diff_ff) * 64'(cfg.index_scale);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
      end else begin
         a_v_ff <= a_v_in;
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_write_ff <= a_write_in;
      a_zero_ff  <= a_zero_in;
      a_sel_ff   <= a_sel_in;
      a_diff_ff  <= a_diff_in;
      a_last_ff  <= a_last_in;
      a_slot_ff  <= req_ch.entry_index;
      a_color_ff <= '{alpha: req_ch.entry_alpha, blue: req_ch.entry_blue,
                      green: req_ch.entry_green, red: req_ch.entry_red};
      b_write_ff <= a_write_ff;
      b_zero_ff  <= a_zero_ff;
      b_sel_ff   <= a_sel_ff;
      b_pos_ff   <= b_pos_in;
      b_last_ff  <= a_last_ff;
      b_slot_ff  <= a_slot_ff;
      b_color_ff <= a_color_ff;
   end

   // The integer part of the position saturates at the last entry in use.
   always_comb begin
      idx  = '0;
      nxt  = '0;
      frac = '0;
      case (b_sel_ff)
         SEL_LAST: begin
            idx = b_last_ff;
            nxt = b_last_ff;
         end
         SEL_INTERP: begin
            if (b_pos_ff[63:32] > 32'(b_last_ff)) begin
               idx = b_last_ff;
            end else begin
               idx = IW'(b_pos_ff[63:32]);
            end
            nxt  = (idx == b_last_ff) ? b_last_ff : idx + IW'(1);
            frac = b_pos_ff[31:16];
         end
         default: begin
            idx = '0;
            nxt = '0;
         end
      endcase
   end

   assign push               = b_v_ff;
   assign push_task.is_write = b_write_ff;
   assign push_task.zero     = b_zero_ff;
   assign push_task.frac     = frac;
   assign push_task.slot     = b_slot_ff;
   assign push_task.color    = b_color_ff;
   assign push_idx           = idx;
   assign push_nxt           = nxt;
endmodule

>>> hw/rtl/tflerp_back.sv
// Back part: color table, two-entry read, per-channel blend and response register.
// Depends on tflerp_pkg and the response interface.
module tflerp_back #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  tflerp_pkg::task_type           q_task,
   input  logic [$clog2(MAX_ENTRIES)-1:0] q_idx,
   input  logic [$clog2(MAX_ENTRIES)-1:0] q_nxt,
   output logic                           pop,
   tflerp_rsp_if.source                   rsp_ch
);
   import tflerp_pkg::*;

   localparam int IW = $clog2(MAX_ENTRIES);

   color_type   table_mem [MAX_ENTRIES];

   logic        b1_v_ff;
   logic        b1_zero_ff;
   logic [15:0] b1_frac_ff;
   color_type   rd_a_ff;
   color_type   rd_b_ff;
   logic        out_v_ff;
   color_type   out_color_ff, out_color_in;
   logic        b1_load;
   logic        out_load;
   logic        slot_ok;

   function automatic logic [15:0] blend16(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] f);
      logic [32:0] sum;
      sum = 33'(a) * 33'(FRAC_ONE - {1'b0, f}) + 33'(b) * 33'(f) + ROUND_HALF;
      return sum[31:16];
   endfunction

   assign out_load = b1_v_ff && (!out_v_ff || rsp_ch.ready);
   assign b1_load  = !b1_v_ff || out_load;
   assign pop      = q_valid && b1_load;
   assign slot_ok  = (32'(q_task.slot) < 32'(MAX_ENTRIES));

   // Writes land when popped, so a later sample always reads them.
   always_ff @(posedge clock) begin
      if (pop && q_task.is_write && slot_ok) begin
         table_mem[IW'(q_task.slot)] <= q_task.color;
      end
   end

   always_ff @(posedge clock) begin
      if (b1_load) begin
         rd_a_ff    <= table_mem[q_idx];
         rd_b_ff    <= table_mem[q_nxt];
         b1_frac_ff <= q_task.frac;
         b1_zero_ff <= q_task.zero;
      end
   end

   always_comb begin
      if (b1_zero_ff) begin
         out_color_in = '0;
      end else begin
         out_color_in.red   = blend16(rd_a_ff.red,   rd_b_ff.red,   b1_frac_ff);
         out_color_in.green = blend16(rd_a_ff.green, rd_b_ff.green, b1_frac_ff);
         out_color_in.blue  = blend16(rd_a_ff.blue,  rd_b_ff.blue,  b1_frac_ff);
         out_color_in.alpha = blend16(rd_a_ff.alpha, rd_b_ff.alpha, b1_frac_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (b1_load) begin
            b1_v_ff <= pop && !q_task.is_write;
         end
         if (out_load) begin
            out_v_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_color_ff <= out_color_in;
      end
   end

   assign rsp_ch.valid     = out_v_ff;
   assign rsp_ch.out_red   = out_color_ff.red;
   assign rsp_ch.out_green = out_color_ff.green;
   assign rsp_ch.out_blue  = out_color_ff.blue;
   assign rsp_ch.out_alpha = out_color_ff.alpha;
endmodule

>>> hw/rtl/transfer_function_lerp_lookup.sv
// Top level of the transfer function lookup: configuration registers and wiring.
// Depends on tflerp_pkg, the channel interfaces, tflerp_front, tflerp_fifo and tflerp_back.
//
// This block maps a signed Q16.16 scalar sample to a 16-bit RGBA color by
// linear interpolation in a table of up to MAX_ENTRIES colors. Table entries
// are loaded with write beats on the request channel (req_type high) and
// produce no response; every sample beat produces exactly one response beat,
// in order. While the response side is ready, the block takes one request
// beat per cycle and returns one response beat per cycle; a sample passes
// through stages A and B, the queue, the table read register and the
// response register. The rate is set by the single 32 by 32 bit position
// multiplier, which sits in a pipeline stage of its own, and by the table,
// which is read at two addresses at once. The front part classifies and
// scales samples, a four-entry queue follows, and the back part reads the
// table, blends and holds the result in a response register, so a response
// stall stops the front only when the queue has no room left. Table entries
// come out of reset undefined: a sample must only reach entries that were
// written, and there is no clearing pass. Configuration writes are taken at
// once and must only be made while the block is idle.
module transfer_function_lerp_lookup #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   tflerp_req_if.sink                         req_ch,
   tflerp_rsp_if.source                       rsp_ch,
   input  logic                               csr_we,
   input  logic [tflerp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                        csr_wdata
);
   import tflerp_pkg::*;

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int TW = $bits(task_type);
   localparam int QW = TW + 2 * IW;

   // Configuration registers, written directly by the plain write port.
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RANGE_LOWER: cfg_in.range_lower = csr_wdata;
            CSR_RANGE_UPPER: cfg_in.range_upper = csr_wdata;
            CSR_INDEX_SCALE: cfg_in.index_scale = csr_wdata;
            CSR_ENTRY_COUNT: cfg_in.entry_count = csr_wdata[8:0];
            default: begin
               // Indexes beyond the register list are ignored.
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_lower <= RANGE_LOWER_RESET;
         cfg_ff.range_upper <= RANGE_UPPER_RESET;
         cfg_ff.index_scale <= INDEX_SCALE_RESET;
         cfg_ff.entry_count <= ENTRY_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front to queue.
   logic            push;
   task_type        push_task;
   logic [IW-1:0]   push_idx;
   logic [IW-1:0]   push_nxt;
   logic [QCW-1:0]  queue_count;

   // Queue to back.
   logic            pop;
   logic            q_valid;
   logic [QW-1:0]   q_data;
   task_type        q_task;
   logic [IW-1:0]   q_idx;
   logic [IW-1:0]   q_nxt;

   tflerp_front #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .cfg         (cfg_ff),
      .queue_count (queue_count),
      .push        (push),
      .push_task   (push_task),
      .push_idx    (push_idx),
      .push_nxt    (push_nxt)
   );

   // The front only issues a beat when the queue is sure to have room for it.
   tflerp_fifo #(
      .WIDTH (QW),
      .DEPTH (QDEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_task, push_idx, push_nxt}),
      .pop       (pop),
      .pop_data  (q_data),
      .not_empty (q_valid),
      .count     (queue_count)
   );

   assign {q_task, q_idx, q_nxt} = q_data;

   tflerp_back #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_task  (q_task),
      .q_idx   (q_idx),
      .q_nxt   (q_nxt),
      .pop     (pop),
      .rsp_ch  (rsp_ch)
   );
endmodule
